/* rtl/b32e_pkg.sv */
// Shared types, constants and the alphabet lookup for the Base32 stream encoder.
package b32e_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [7:0]  PAD_CHAR = 8'h3D;
   localparam logic [3:0]  MAX_RESULTS = 4'd8;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_OVF,
      TAIL_STATUS
   } tail_type;

   // One queued unit of work: up to three alphabet codes, then pads, then a tail result.
   typedef struct packed {
      logic [2:0][4:0] chars;
      logic [1:0]      n_alpha;
      logic [3:0]      n_emit;
      tail_type        tail;
      logic [15:0]     total;
   } job_type;

   function automatic logic [7:0] b32_char(input logic [4:0] code);
      logic [7:0] ch;
      if (code < 5'd26) begin
         ch = 8'h41 + 8'(code);
      end else begin
         ch = 8'h32 + 8'(code - 5'd26);
      end
      return ch;
   endfunction

endpackage

/* rtl/b32e_front.sv */
// Front end: accepts bytes, slices 5-bit groups, checks capacity and builds jobs.
module b32e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                has_byte,
   input  logic                is_last,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                job_valid,
   output b32e_pkg::job_type   job
);

   logic [11:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] cc_ff, cc_in;
   logic        aborted_ff, aborted_in;
   logic [15:0] cap_ff;

   logic [11:0] buf_cat, buf_rem;
   logic [3:0]  cnt_a, sh0, sh1, cnt_rem;
   logic        two;
   logic [4:0]  c0, c1, flush_ch;
   logic [1:0]  k_byte, k_last;
   logic        flush_needed;
   logic [2:0]  sum3, pad;
   logic [16:0] total, cc17, cap17;
   logic [3:0]  emit_raw, emit;
   logic        ovf0, ovf1;

   // Slice the byte into groups, most significant bits first.
   always_comb begin
      buf_cat  = {buf_ff[3:0], data_byte};
      cnt_a    = cnt_ff + 4'd8;
      sh0      = cnt_a - 4'd5;
      c0       = 5'(buf_cat >> sh0);
      two      = (sh0 >= 4'd5);
      sh1      = sh0 - 4'd5;
      c1       = 5'(buf_cat >> sh1);
      if (has_byte) begin
         k_byte  = two ? 2'd2 : 2'd1;
         cnt_rem = two ? sh1 : sh0;
         buf_rem = buf_cat;
      end else begin
         k_byte  = 2'd0;
         cnt_rem = cnt_ff;
         buf_rem = buf_ff;
      end
      flush_needed = (cnt_rem != 4'd0);
      flush_ch     = 5'(buf_rem << (4'd5 - cnt_rem));
      k_last       = k_byte + 2'(flush_needed);
      sum3         = 3'(cc_ff[2:0] + 3'(k_last));
      pad          = 3'(3'd0 - sum3);
      cc17         = {1'b0, cc_ff};
      cap17        = {1'b0, cap_ff};
      total        = cc17 + 17'(k_last) + 17'(pad);
      emit_raw     = 4'(k_last) + 4'(pad);
      emit         = (emit_raw > b32e_pkg::MAX_RESULTS) ? b32e_pkg::MAX_RESULTS : emit_raw;
      ovf0         = (k_byte != 2'd0) && (cc17 >= cap17);
      ovf1         = (k_byte == 2'd2) && ((cc17 + 17'd1) >= cap17);
   end

   // Classify the item and pick the next message state.
   always_comb begin
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      cc_in      = cc_ff;
      aborted_in = aborted_ff;
      job_valid  = 1'b0;
      job.chars[0] = (k_byte == 2'd0) ? flush_ch : c0;
      job.chars[1] = (k_byte == 2'd1) ? flush_ch : c1;
      job.chars[2] = flush_ch;
      job.n_alpha  = 2'd0;
      job.n_emit   = 4'd0;
      job.tail     = b32e_pkg::TAIL_NONE;
      job.total    = 16'd0;
      if (accept) begin
         if (aborted_ff) begin
            if (is_last) begin
               buf_in     = '0;
               cnt_in     = '0;
               cc_in      = '0;
               aborted_in = 1'b0;
            end
         end else if (!is_last) begin
            if (ovf0 || ovf1) begin
               job_valid   = 1'b1;
               job.n_alpha = ovf1 && !ovf0 ? 2'd1 : 2'd0;
               job.n_emit  = ovf1 && !ovf0 ? 4'd1 : 4'd0;
               job.tail    = b32e_pkg::TAIL_OVF;
               buf_in      = '0;
               cnt_in      = '0;
               cc_in       = '0;
               aborted_in  = 1'b1;
            end else begin
               job_valid   = (k_byte != 2'd0);
               job.n_alpha = k_byte;
               job.n_emit  = 4'(k_byte);
               buf_in      = buf_rem;
               cnt_in      = cnt_rem;
               cc_in       = cc_ff + 16'(k_byte);
            end
         end else begin
            job_valid  = 1'b1;
            buf_in     = '0;
            cnt_in     = '0;
            cc_in      = '0;
            aborted_in = 1'b0;
            if (total >= cap17) begin
               job.tail = b32e_pkg::TAIL_OVF;
            end else if (emit_raw == 4'd0) begin
               job.tail  = b32e_pkg::TAIL_STATUS;
               job.total = 16'(total);
            end else begin
               job.n_alpha = k_last;
               job.n_emit  = emit;
               job.total   = 16'(total);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         cnt_ff     <= '0;
         cc_ff      <= '0;
         aborted_ff <= 1'b0;
         cap_ff     <= b32e_pkg::CAPACITY_RESET;
      end else begin
         buf_ff     <= buf_in;
         cnt_ff     <= cnt_in;
         cc_ff      <= cc_in;
         aborted_ff <= aborted_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

endmodule

/* rtl/b32e_queue.sv */
// Short job queue between the front end and the emitter.
module b32e_queue #(
   parameter int unsigned DEPTH = b32e_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b32e_pkg::job_type   push_job,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output b32e_pkg::job_type   head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   b32e_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

/* rtl/b32e_back.sv */
// Back end: steps through each queued job and drives one result per transfer.
module b32e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  b32e_pkg::job_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_char_valid,
   output logic                rsp_run_last,
   output logic                rsp_overflow,
   output logic [15:0]         rsp_total_length
);

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        cval_ff, cval_in;
   logic        last_ff, last_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] total_ff, total_in;

   logic [3:0]  n_res;
   logic        in_char, is_final, load;

   always_comb begin
      n_res    = head.n_emit + 4'(head.tail != b32e_pkg::TAIL_NONE);
      in_char  = (idx_ff < head.n_emit);
      is_final = (idx_ff == n_res - 4'd1);
      load     = head_valid && (!valid_ff || rsp_ready);
      pop      = load && is_final;
      if (pop) begin
         idx_in = '0;
      end else if (load) begin
         idx_in = idx_ff + 4'd1;
      end else begin
         idx_in = idx_ff;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Shape the result at the current position of the job.
   always_comb begin
      if (in_char) begin
         char_in  = (idx_ff < 4'(head.n_alpha))
                    ? b32e_pkg::b32_char(head.chars[idx_ff[1:0]]) : b32e_pkg::PAD_CHAR;
         cval_in  = 1'b1;
         last_in  = is_final;
         ovf_in   = 1'b0;
         total_in = is_final ? head.total : 16'd0;
      end else begin
         char_in  = 8'd0;
         cval_in  = 1'b0;
         last_in  = 1'b1;
         ovf_in   = (head.tail == b32e_pkg::TAIL_OVF);
         total_in = head.total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= char_in;
         cval_ff  <= cval_in;
         last_ff  <= last_in;
         ovf_ff   <= ovf_in;
         total_ff <= total_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_char_valid   = cval_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_total_length = total_ff;

endmodule

/* rtl/base32_stream_encoder.sv */
// Top level of the streaming Base32 encoder: front end, job queue and emitter.
//
// Streaming Base32 encoder (standard alphabet A-Z, 2-7). Each transfer on the
// req_ channel carries at most one message byte; the item with req_is_last set
// flushes the leftover bits as one more character, pads with '=' to a multiple
// of eight characters and reports the encoded length on its final result. The
// csr_ register holds the output capacity including one terminator slot; a
// message whose characters or final length would not fit produces a single
// overflow result and the rest of the message is dropped up to its last item.
// The front end classifies every item in the cycle it is taken, so req_ready
// stays high as long as the job queue (QUEUE_DEPTH entries) has room. The
// emitter drives one result per cycle while rsp_ready is high, through a
// registered output stage, so throughput is set by that single result port: a
// byte item yields one or two results, an ending item up to eight. Bursts of
// bytes are absorbed by the queue while rsp_ready is low. There is no reset
// sweep; the block takes items from the first cycle after reset.
module base32_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_char_valid,
   output logic        rsp_run_last,
   output logic        rsp_overflow,
   output logic [15:0] rsp_total_length,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic              accept;
   logic              job_valid;
   b32e_pkg::job_type job;
   logic              full;
   logic              head_valid;
   b32e_pkg::job_type head;
   logic              pop;

   // Take a new item whenever the queue can hold the job it may produce.
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   b32e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .is_last   (req_is_last),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_valid (job_valid),
      .job       (job)
   );

   // Decouple classification from emission.
   b32e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Emit one result per transfer, popping the job with its final result.
   b32e_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_overflow     (rsp_overflow),
      .rsp_total_length (rsp_total_length)
   );

endmodule

/* rtl/b32e_checker.sv */
// Port-level checks for the Base32 stream encoder and their binding.
module b32e_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_char,
   input logic        rsp_char_valid,
   input logic        rsp_run_last,
   input logic        rsp_overflow,
   input logic [15:0] rsp_total_length
);

   // Overflow ends the run with an empty status result.
   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_run_last && !rsp_char_valid
                                    && rsp_total_length == 16'd0 && rsp_out_char == 8'd0)
      else $error("overflow result malformed");

   // A status-only result always closes its item.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_run_last && rsp_out_char == 8'd0)
      else $error("status result not last or carries a character");

   // Characters come from the alphabet or are pads.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |->
         (rsp_out_char >= 8'h41 && rsp_out_char <= 8'h5A) ||
         (rsp_out_char >= 8'h32 && rsp_out_char <= 8'h37) ||
         rsp_out_char == 8'h3D)
      else $error("character outside alphabet");

   // Length is reported only on a closing result.
   a_len_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_length != 16'd0 |-> rsp_run_last && !rsp_overflow)
      else $error("length on a non-final result");

   // A stalled transfer holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_run_last) && $stable(rsp_total_length))
      else $error("result changed while stalled");

endmodule

bind base32_stream_encoder b32e_checker u_b32e_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_char     (rsp_out_char),
   .rsp_char_valid   (rsp_char_valid),
   .rsp_run_last     (rsp_run_last),
   .rsp_overflow     (rsp_overflow),
   .rsp_total_length (rsp_total_length)
);
